@@ rtl/sil_pkg.sv @@
// Shared types and constants for the serial image loader.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package sil_pkg;

  localparam int ADDRESS_WIDTH = 64;
  localparam int SUM_WIDTH     = 40;
  localparam int SIZE_WIDTH    = 32;
  localparam int CFG_WIDTH     = 64;

  localparam logic [2:0] HDR_LAST      = 3'd7;
  localparam logic [2:0] HDR_SIZE_LAST = 3'd3;

  typedef enum logic {
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  // input stage contents handed to the core
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    logic                     write_valid;
    logic [ADDRESS_WIDTH-1:0] write_address;
    logic [7:0]               write_data;
    logic                     done_res;
    logic                     checksum_ok;
    logic [SUM_WIDTH-1:0]     computed_sum;
  } result_t;

endpackage

@@ rtl/sil_rx_if.sv @@
// Channel interfaces: received byte requests and loader results.
// Depends on sil_pkg for widths.
`timescale 1ns / 1ps

interface sil_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sil_res_if import sil_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     write_valid;
  logic [ADDRESS_WIDTH-1:0] write_address;
  logic [7:0]               write_data;
  logic                     done_res;
  logic                     checksum_ok;
  logic [SUM_WIDTH-1:0]     computed_sum;

  modport source (output valid, output write_valid, output write_address,
                  output write_data, output done_res, output checksum_ok,
                  output computed_sum, input ready);
  modport sink   (input valid, input write_valid, input write_address,
                  input write_data, input done_res, input checksum_ok,
                  input computed_sum, output ready);
endinterface

@@ rtl/sil_in_reg.sv @@
// Input register stage for received bytes.
// Depends on sil_pkg and sil_rx_if.
`timescale 1ns / 1ps

module sil_in_reg import sil_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  sil_rx_if.sink rx,
  input  logic   take,
  output stage_t stage
);

  logic       valid;
  logic [7:0] data;

  assign rx.ready = !valid || take;
  assign stage    = '{valid: valid, data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      data <= rx.rx_byte;
    end
  end

endmodule

@@ rtl/sil_core.sv @@
// Loader state: header parse, payload address/sum, verdict.
// Depends on sil_pkg.
`timescale 1ns / 1ps

module sil_core import sil_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  input  stage_t               stage,
  input  logic                 out_free,
  output logic                 take,
  output logic                 res_valid,
  output result_t              res
);

  phase_t                phase, phase_next;
  logic [2:0]            header_count, header_count_next;
  logic [SIZE_WIDTH-1:0] image_size, image_size_next;
  logic [SIZE_WIDTH-1:0] expected_checksum, expected_checksum_next;
  logic [SIZE_WIDTH-1:0] bytes_received, bytes_received_next;
  logic [SUM_WIDTH-1:0]  running_sum, running_sum_next;
  logic [CFG_WIDTH-1:0]  load_address;

  logic [SUM_WIDTH-1:0]  sum_inc;
  logic [SIZE_WIDTH-1:0] count_inc;
  logic [CFG_WIDTH-1:0]  addr_full;
  logic                  last_byte;
  logic [4:0]            lane;

  assign take      = stage.valid && out_free;
  assign sum_inc   = running_sum + {{(SUM_WIDTH-8){1'b0}}, stage.data};
  assign count_inc = bytes_received + {{(SIZE_WIDTH-1){1'b0}}, 1'b1};
  assign addr_full = load_address + {{(CFG_WIDTH-SIZE_WIDTH){1'b0}}, bytes_received};
  assign last_byte = (count_inc == image_size);
  assign lane      = {header_count[1:0], 3'b000};

  // next state
  always_comb begin
    phase_next             = phase;
    header_count_next      = header_count;
    image_size_next        = image_size;
    expected_checksum_next = expected_checksum;
    bytes_received_next    = bytes_received;
    running_sum_next       = running_sum;
    if (take) begin
      case (phase)
        PH_HEADER: begin
          if (header_count <= HDR_SIZE_LAST) begin
            image_size_next[lane +: 8] = stage.data;
          end else begin
            expected_checksum_next[lane +: 8] = stage.data;
          end
          if (header_count == HDR_LAST) begin
            header_count_next   = '0;
            bytes_received_next = '0;
            running_sum_next    = '0;
            if (image_size != '0) begin
              phase_next = PH_PAYLOAD;
            end
          end else begin
            header_count_next = header_count + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          running_sum_next    = sum_inc;
          bytes_received_next = count_inc;
          if (last_byte) begin
            phase_next        = PH_HEADER;
            header_count_next = '0;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (phase)
      PH_HEADER: begin
        // empty image: verdict on the last header byte
        if (header_count == HDR_LAST && image_size == '0) begin
          res_valid       = take;
          res.done_res    = 1'b1;
          res.checksum_ok = ({stage.data, expected_checksum[23:0]} == '0);
        end
      end
      PH_PAYLOAD: begin
        res_valid         = take;
        res.write_valid   = 1'b1;
        res.write_address = addr_full[ADDRESS_WIDTH-1:0];
        res.write_data    = stage.data;
        res.computed_sum  = sum_inc;
        res.done_res      = last_byte;
        // negative checksum never matches
        res.checksum_ok   = last_byte && !expected_checksum[SIZE_WIDTH-1] &&
                            (sum_inc == {{(SUM_WIDTH-SIZE_WIDTH){1'b0}}, expected_checksum});
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_count      <= '0;
      image_size        <= '0;
      expected_checksum <= '0;
      bytes_received    <= '0;
      running_sum       <= '0;
      load_address      <= '0;
    end else begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      image_size        <= image_size_next;
      expected_checksum <= expected_checksum_next;
      bytes_received    <= bytes_received_next;
      running_sum       <= running_sum_next;
      if (cfg_we) begin
        load_address <= cfg_wdata;
      end
    end
  end

endmodule

@@ rtl/sil_out_reg.sv @@
// Result register driving the result channel.
// Depends on sil_pkg and sil_res_if.
`timescale 1ns / 1ps

module sil_out_reg import sil_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res_in,
  sil_res_if.source  res,
  output logic       out_free
);

  logic    valid;
  result_t data;

  assign out_free          = !valid || res.ready;
  assign res.valid         = valid;
  assign res.write_valid   = data.write_valid;
  assign res.write_address = data.write_address;
  assign res.write_data    = data.write_data;
  assign res.done_res      = data.done_res;
  assign res.checksum_ok   = data.checksum_ok;
  assign res.computed_sum  = data.computed_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res_in;
    end
  end

endmodule

@@ rtl/serial_image_loader_checksum.sv @@
// Top level of the serial image loader with additive checksum.
// Depends on sil_pkg, sil_rx_if, sil_in_reg, sil_core, sil_out_reg.
//
// Usage:
//   rx  : one received byte per request (valid/ready). Bytes 0..3 are the
//         little-endian image size, 4..7 the signed checksum, then payload.
//   res : one result per payload byte (a write at load address + index, with
//         the running sum); the last one carries done_res and checksum_ok.
//         An empty image gives a single verdict on the eighth header byte.
//   cfg : cfg_we/cfg_wdata write the 64-bit load address; write it only
//         while no byte is in flight.
// Timing: a taken request is held in the input register, processed by the core
//   and its result registered in the result register, so res.valid rises once
//   the result is registered. While res.ready stays high, one byte per cycle is
//   sustained; the input register and the result register each hold one entry.
// Reset (rst, synchronous) empties both registers, clears the load address
//   and returns to header reception. When the receiver stalls, the result
//   holds, an empty input register takes one more byte, then rx.ready drops.
`timescale 1ns / 1ps

module serial_image_loader_checksum import sil_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  sil_rx_if.sink               rx,
  sil_res_if.source            res
);

  stage_t  stage;
  result_t core_res;
  logic    take;
  logic    core_valid;
  logic    out_free;

  sil_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (take),
    .stage (stage)
  );

  sil_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .out_free  (out_free),
    .take      (take),
    .res_valid (core_valid),
    .res       (core_res)
  );

  sil_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (core_valid),
    .res_in   (core_res),
    .res      (res),
    .out_free (out_free)
  );

endmodule

@@ rtl/sil_checker.sv @@
// Port-level checks for the serial image loader, bound to the top level.
// Depends on sil_pkg and serial_image_loader_checksum.
`timescale 1ns / 1ps

module sil_checker import sil_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic                     write_valid,
  input logic [ADDRESS_WIDTH-1:0] write_address,
  input logic [7:0]               write_data,
  input logic                     done_res,
  input logic                     checksum_ok,
  input logic [SUM_WIDTH-1:0]     computed_sum
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(write_address) &&
    $stable(computed_sum) && $stable(done_res))
    else $error("stalled result changed");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !write_valid |-> write_address == '0 && write_data == '0 &&
    done_res && computed_sum == '0)
    else $error("non-write result is not an empty-image verdict");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && checksum_ok |-> done_res)
    else $error("checksum_ok without done");

endmodule

bind serial_image_loader_checksum sil_checker u_sil_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .write_valid   (res.write_valid),
  .write_address (res.write_address),
  .write_data    (res.write_data),
  .done_res      (res.done_res),
  .checksum_ok   (res.checksum_ok),
  .computed_sum  (res.computed_sum)
);

@@ tb/tb_serial_image_loader_checksum.sv @@
// Self-checking bench for serial_image_loader_checksum: sends framed images
// (size, checksum, payload) and predicts every write and verdict.
// Depends on sil_pkg, sil_rx_if, sil_res_if and the loader RTL.
`timescale 1ns / 1ps

import sil_pkg::*;

typedef logic [7:0] byte_q_t[$];

// Tracks the loader state and holds the writes and verdicts still to come.
class sil_scoreboard;
  logic [63:0]     load_addr;
  phase_t          phase;
  logic [2:0]      hdr_pos;
  logic [31:0]     image_size;
  logic [31:0]     image_chk;
  logic [31:0]     byte_count;
  logic [39:0]     byte_sum;
  result_t         pending_q[$];
  int              errors;

  function new();
    load_addr  = '0;
    phase      = PH_HEADER;
    hdr_pos    = '0;
    image_size = '0;
    image_chk  = '0;
    byte_count = '0;
    byte_sum   = '0;
    errors     = 0;
  endfunction

  function void set_load_address(logic [63:0] addr);
    load_addr = addr;
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  function void note_byte(logic [7:0] b);
    result_t     r;
    logic [63:0] addr;
    int          pos;
    r   = '0;
    pos = hdr_pos;
    if (phase == PH_HEADER) begin
      if (hdr_pos <= HDR_SIZE_LAST) image_size[pos*8 +: 8] = b;
      else image_chk[(pos-4)*8 +: 8] = b;
      if (hdr_pos != HDR_LAST) begin
        hdr_pos = hdr_pos + 3'd1;
        return;
      end
      hdr_pos    = '0;
      byte_count = '0;
      byte_sum   = '0;
      if (image_size == 0) begin
        // empty image: verdict right on the last header byte
        r.done_res    = 1'b1;
        r.checksum_ok = (image_chk == 32'd0);
        pending_q.push_back(r);
      end else begin
        phase = PH_PAYLOAD;
      end
    end else begin
      addr            = load_addr + 64'(byte_count);
      r.write_valid   = 1'b1;
      r.write_address = addr[ADDRESS_WIDTH-1:0];
      r.write_data    = b;
      byte_sum        = byte_sum + 40'(b);
      byte_count      = byte_count + 32'd1;
      r.computed_sum  = byte_sum;
      if (byte_count == image_size) begin
        r.done_res    = 1'b1;
        // negative checksum can never match
        r.checksum_ok = !image_chk[31] && (byte_sum == {8'd0, image_chk});
        phase         = PH_HEADER;
        hdr_pos       = '0;
      end
      pending_q.push_back(r);
    end
  endfunction

  function void cmp_field(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual %0h", $time, got);
      return;
    end
    want = pending_q.pop_front();
    cmp_field("write_valid", 64'(want.write_valid), 64'(got.write_valid));
    cmp_field("write_address", 64'(want.write_address), 64'(got.write_address));
    cmp_field("write_data", 64'(want.write_data), 64'(got.write_data));
    cmp_field("done_res", 64'(want.done_res), 64'(got.done_res));
    cmp_field("checksum_ok", 64'(want.checksum_ok), 64'(got.checksum_ok));
    cmp_field("computed_sum", 64'(want.computed_sum), 64'(got.computed_sum));
  endfunction
endclass

module tb_serial_image_loader_checksum;

  typedef enum int {RDY_OPEN, RDY_COIN, RDY_STALLS} rdy_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_WIDTH-1:0] cfg_wdata;

  sil_rx_if  rx_ch ();
  sil_res_if res_ch ();

  serial_image_loader_checksum u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  sil_scoreboard sb;
  int            burst_left;
  int            sent_count;
  int            rdy_window;
  int            stall_left;
  rdy_mode_t     rdy_mode;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: checks accepted results and stalls on its own pattern
  always @(posedge clk) begin
    result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.write_valid   = res_ch.write_valid;
      got.write_address = res_ch.write_address;
      got.write_data    = res_ch.write_data;
      got.done_res      = res_ch.done_res;
      got.checksum_ok   = res_ch.checksum_ok;
      got.computed_sum  = res_ch.computed_sum;
      sb.check_result(got);
    end
    if (rdy_window == 0) begin
      rdy_window = $urandom_range(20, 120);
      rdy_mode   = rdy_mode_t'($urandom_range(0, 2));
    end
    rdy_window--;
    case (rdy_mode)
      RDY_OPEN: res_ch.ready <= 1'b1;
      RDY_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          res_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 20);
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  // sender: bursts of random length separated by random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sb.note_byte(b);
    burst_left--;
    sent_count++;
  endtask

  // load address may only change once the loader has drained
  task automatic write_load_address(input logic [63:0] addr);
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_load_address(addr);
  endtask

  function automatic logic [63:0] pick_address();
    case ($urandom_range(0, 5))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'hFFFF_FFFF_FFFF_FFF8;
      3:       return 64'h8000_0000_0000_0000;
      4:       return 64'h0000_0000_FFFF_FFFC;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // cfg_at: payload index before which the load address is rewritten, -1 for none
  task automatic send_image(input byte_q_t payload, input logic [31:0] chk, input int cfg_at);
    logic [31:0] size;
    size = payload.size();
    for (int i = 0; i < 4; i++) send_byte(size[i*8 +: 8]);
    for (int i = 0; i < 4; i++) send_byte(chk[i*8 +: 8]);
    foreach (payload[i]) begin
      if (i == cfg_at) write_load_address(pick_address());
      send_byte(payload[i]);
    end
  endtask

  initial begin
    byte_q_t     payload;
    logic [31:0] sum;
    logic [31:0] chk;
    int          size;
    int          cfg_at;
    sb            = new();
    burst_left    = 0;
    sent_count    = 0;
    rdy_window    = 0;
    stall_left    = 0;
    rdy_mode      = RDY_OPEN;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty images: zero checksum passes, sign bit alone fails
    payload = {};
    send_image(payload, 32'd0, -1);
    send_image(payload, 32'h8000_0000, -1);
    // byte extremes, address wrap past all ones
    write_load_address('1);
    payload = {8'hFF, 8'h00, 8'h80};
    send_image(payload, 32'h0000_017F, -1);

    // one long image so the sum spills into the upper checksum bytes
    payload = {};
    sum = 0;
    for (int i = 0; i < 300; i++) begin
      payload.push_back(8'($urandom_range(128, 255)));
      sum += payload[i];
    end
    send_image(payload, sum, -1);

    while (sent_count < 1400) begin
      if ($urandom_range(0, 9) == 0) write_load_address(pick_address());
      case ($urandom_range(0, 99)) inside
        [0:11]:  size = 0;
        [12:94]: size = $urandom_range(1, 24);
        default: size = $urandom_range(25, 90);
      endcase
      payload = {};
      sum = 0;
      for (int i = 0; i < size; i++) begin
        if ($urandom_range(0, 9) == 0) payload.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
        else payload.push_back(8'($urandom_range(0, 255)));
        sum += payload[i];
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: chk = sum;
        6:                chk = sum + 32'd1;
        7:                chk = sum - 32'd1;
        8:                chk = sum | 32'h8000_0000;
        default:          chk = $urandom();
      endcase
      cfg_at = (size >= 2 && $urandom_range(0, 6) == 0) ? $urandom_range(1, size - 1) : -1;
      send_image(payload, chk, cfg_at);
    end

    rx_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_serial_image_loader_checksum: done, clean");
    end else begin
      $display("tb_serial_image_loader_checksum: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_serial_image_loader_checksum: done, errors");
    $finish;
  end

endmodule
